// ===== rtl/jhrs_pkg.sv =====
// Package with the payload types and constants of the jump hash replica selector.
`timescale 1ns / 1ps
package jhrs_pkg;

  localparam int MAX_BUCKETS_DEF = 32;
  localparam int BUCKET_W        = 5;
  localparam int CFG_W           = 6;
  localparam int KEY_W           = 64;
  localparam int HALF_W          = 32;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(1);

  localparam logic [KEY_W-1:0] JUMP_MULT     = 64'd2862933555777941757;
  localparam logic [KEY_W-1:0] SCRAMBLE_MULT = 64'd2685821657736338717;

  localparam int JUMP_SHIFT = 31;
  localparam int KEY_SHIFT  = 33;
  localparam int XS_A       = 12;
  localparam int XS_B       = 25;
  localparam int XS_C       = 27;

  typedef struct packed {
    logic [KEY_W-1:0] key_hash;
    logic [CFG_W-1:0] replica_count;
  } in_beat_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic                last;
  } out_beat_t;

endpackage

// ===== rtl/jump_hash_replica_select.sv =====
// Top level of the jump hash replica selector.
`timescale 1ns / 1ps
// Usage: write the bucket count on the cfg_ channel (cfg_ready is always high) while the
// block is idle. Each input beat carries a 64-bit key hash and a replica count. The block
// answers with min(replica_count, bucket_count, MAX_BUCKETS) output beats, each naming a distinct bucket,
// with last set on the final one; a zero count on either side gives no output at all.
// One pick runs the jump hash loop; every jump iteration costs one 64-bit multiply done as
// four passes through a single 32x32 multiplier, the setup states JSET and DINIT, and a
// restoring divide that retires one quotient bit per cycle. A pick takes roughly ln(n)+1
// iterations over the n buckets still left, then emits the result, rescrambles the key
// (another four-pass multiply) and patches the remaining list in its memory.
// The remaining list is a memory with one valid bit per entry; an entry never written since
// the item began reads as its own index, so no clearing pass is needed.
// in_stall is high from the accepted beat until the last result has been placed in the
// output register; a result waiting there under out_stall only holds the block when the
// next result is ready. Reset (rst_n low, synchronous) sets the bucket count to 1 and
// drops any item in flight and any pending output beat.
module jump_hash_replica_select #(
  parameter int MAX_BUCKETS = jhrs_pkg::MAX_BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  jhrs_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output jhrs_pkg::out_beat_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jhrs_pkg::CFG_W-1:0]    cfg_bucket_count
);
  import jhrs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int IDX_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NUM_W  = CNT_W + JUMP_SHIFT;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W + 1;

  typedef enum logic [3:0] {
    IDLE, JMUL, JSET, DINIT, JDIV, JCHK, RDJ, EMIT, SCR, SMUL, SSET, RDL, WRB
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     bucket_count_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     total_r;
  logic [CNT_W-1:0]     emitted_r;
  logic [CNT_W-1:0]     b_r;
  logic [KEY_W-1:0]     work_key_r;
  logic [KEY_W-1:0]     jkey_r;
  logic [KEY_W-1:0]     acc_r;
  logic [KEY_W-1:0]     prod_r;
  logic [1:0]           ph_r;
  logic [NUM_W-1:0]     n_r;
  logic [HALF_W-1:0]    rem_r;
  logic [HALF_W-1:0]    d_r;
  logic [DCNT_W-1:0]    dcnt_r;
  logic [MAX_BUCKETS-1:0] vld_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;

  logic [BUCKET_W-1:0]  mem [MAX_BUCKETS];
  logic [BUCKET_W-1:0]  mem_q_r;
  logic                 vld_q_r;
  logic [IDX_W-1:0]     idx_q_r;

  logic [CNT_W-1:0]     nb;
  logic [CNT_W-1:0]     total;
  logic [IDX_W-1:0]     rd_addr;
  logic [BUCKET_W-1:0]  lval;
  logic [KEY_W-1:0]     mul_src;
  logic [KEY_W-1:0]     mul_cst;
  logic [HALF_W-1:0]    mul_a;
  logic [HALF_W-1:0]    mul_b;
  logic [HALF_W:0]      div_t;
  logic                 div_ge;
  logic [KEY_W-1:0]     xs1;
  logic [KEY_W-1:0]     xs2;
  logic [KEY_W-1:0]     key_xs_nxt;
  logic                 in_acc;
  logic                 out_load;
  logic                 last_pick;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective bucket count saturates at the list depth.
  always_comb begin
    if (CMP_W'(bucket_count_r) >= CMP_W'(MAX_BUCKETS)) begin
      nb = CNT_W'(MAX_BUCKETS);
    end else begin
      nb = CNT_W'(bucket_count_r);
    end
    if (CMP_W'(in_data.replica_count) < CMP_W'(nb)) begin
      total = CNT_W'(in_data.replica_count);
    end else begin
      total = nb;
    end
  end

  // The picked slot stays addressed while its result waits for the output register.
  assign rd_addr = ((state_r == RDJ) || (state_r == EMIT)) ? b_r[IDX_W-1:0]
                                                           : count_r[IDX_W-1:0];
  assign lval    = vld_q_r ? mem_q_r : BUCKET_W'(idx_q_r);

  // Shared 32x32 multiplier; the low 64 bits of a 64x64 product take four passes.
  assign mul_src = (state_r == SMUL) ? work_key_r : jkey_r;
  assign mul_cst = (state_r == SMUL) ? SCRAMBLE_MULT : JUMP_MULT;
  always_comb begin
    case (ph_r)
      2'd1: begin
        mul_a = mul_src[KEY_W-1:HALF_W];
        mul_b = mul_cst[HALF_W-1:0];
      end
      2'd2: begin
        mul_a = mul_src[HALF_W-1:0];
        mul_b = mul_cst[KEY_W-1:HALF_W];
      end
      default: begin
        mul_a = mul_src[HALF_W-1:0];
        mul_b = mul_cst[HALF_W-1:0];
      end
    endcase
  end

  assign div_t  = {rem_r, n_r[NUM_W-1]};
  assign div_ge = (div_t >= {1'b0, d_r});

  assign xs1        = work_key_r ^ (work_key_r >> XS_A);
  assign xs2        = xs1 ^ (xs1 << XS_B);
  assign key_xs_nxt = xs2 ^ (xs2 >> XS_C);

  assign out_load  = (state_r == EMIT) && (!out_valid_r || !out_stall);
  assign last_pick = ((emitted_r + CNT_W'(1)) == total_r);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == WRB) begin
      mem[b_r[IDX_W-1:0]] <= lval;
    end
    mem_q_r <= mem[rd_addr];
    vld_q_r <= vld_r[rd_addr];
    idx_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= IDLE;
      bucket_count_r <= BUCKET_COUNT_RST;
      out_valid_r    <= 1'b0;
      vld_r          <= '0;
      ph_r           <= 2'd0;
      count_r        <= '0;
      work_key_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bucket_count_r <= cfg_bucket_count;
      end
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_acc) begin
            work_key_r <= in_data.key_hash;
            jkey_r     <= in_data.key_hash;
            count_r    <= nb;
            total_r    <= total;
            emitted_r  <= '0;
            b_r        <= '0;
            vld_r      <= '0;
            ph_r       <= 2'd0;
            if (total != '0) begin
              state_r <= JMUL;
            end
          end
        end
        JMUL, SMUL: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd1) begin
            acc_r <= prod_r;
          end else if (ph_r != 2'd0) begin
            acc_r[KEY_W-1:HALF_W] <= acc_r[KEY_W-1:HALF_W] + prod_r[HALF_W-1:0];
          end
          if (ph_r == 2'd3) begin
            state_r <= (state_r == SMUL) ? SSET : JSET;
          end
        end
        JSET: begin
          jkey_r  <= acc_r + KEY_W'(1);
          state_r <= DINIT;
        end
        DINIT: begin
          d_r     <= HALF_W'(jkey_r[KEY_W-1:KEY_SHIFT]) + HALF_W'(1);
          n_r     <= NUM_W'(b_r + CNT_W'(1)) << JUMP_SHIFT;
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= JDIV;
        end
        JDIV: begin
          rem_r  <= div_ge ? HALF_W'(div_t - {1'b0, d_r}) : HALF_W'(div_t);
          n_r    <= {n_r[NUM_W-2:0], div_ge};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(NUM_W - 1)) begin
            state_r <= JCHK;
          end
        end
        JCHK: begin
          // The quotient is the next jump target; stop once it leaves the bucket range.
          if (n_r < NUM_W'(count_r)) begin
            b_r     <= n_r[CNT_W-1:0];
            ph_r    <= 2'd0;
            state_r <= JMUL;
          end else begin
            state_r <= RDJ;
          end
        end
        RDJ: begin
          state_r <= EMIT;
        end
        EMIT: begin
          if (out_load) begin
            out_valid_r       <= 1'b1;
            out_data_r.bucket <= lval;
            out_data_r.last   <= last_pick;
            emitted_r         <= emitted_r + CNT_W'(1);
            state_r           <= last_pick ? IDLE : SCR;
          end
        end
        SCR: begin
          work_key_r <= key_xs_nxt;
          ph_r       <= 2'd0;
          state_r    <= SMUL;
        end
        SSET: begin
          work_key_r <= acc_r;
          count_r    <= count_r - CNT_W'(1);
          state_r    <= RDL;
        end
        RDL: begin
          state_r <= WRB;
        end
        WRB: begin
          // The last remaining bucket moves into the slot just picked.
          vld_r[b_r[IDX_W-1:0]] <= 1'b1;
          jkey_r  <= work_key_r;
          b_r     <= '0;
          ph_r    <= 2'd0;
          state_r <= JMUL;
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != IDLE) |-> (count_r != '0))
    else $error("remaining count reached zero during an item");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RDJ) |-> (b_r < count_r))
    else $error("picked slot beyond the remaining buckets");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == JDIV) |-> (d_r != '0))
    else $error("jump divisor is zero");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_pick) |=> (state_r == IDLE && out_valid_r && out_data_r.last))
    else $error("final result did not end the item");

  a_emitted_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EMIT) |-> (emitted_r < total_r))
    else $error("more results than requested");

endmodule

// ===== tb/jump_hash_replica_select_tb.sv =====
// Self-checking testbench for the jump hash replica selector.
`timescale 1ns / 1ps
module jump_hash_replica_select_tb;
  import jhrs_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYC = 80;

  // Keeps the bucket lists that the block should produce for accepted beats.
  class bucket_scoreboard;
    logic [CFG_W-1:0] bucket_count;
    out_beat_t        picks_due[$];
    int               mismatches;

    function new();
      bucket_count = BUCKET_COUNT_RST;
      mismatches   = 0;
    endfunction

    function automatic logic [BUCKET_W-1:0] jump_bucket(logic [KEY_W-1:0] key,
                                                        int unsigned n);
      logic [KEY_W-1:0] b;
      logic [KEY_W-1:0] j;
      b = '0;
      j = '0;
      while (j < n) begin
        b   = j;
        key = key * JUMP_MULT + 64'd1;
        j   = ((b + 64'd1) << JUMP_SHIFT) / ((key >> KEY_SHIFT) + 64'd1);
      end
      return b[BUCKET_W-1:0];
    endfunction

    function void note_input(in_beat_t beat);
      logic [BUCKET_W-1:0] left_list [MAX_BUCKETS_DEF];
      logic [KEY_W-1:0]    key;
      int unsigned         left, total, nb, emitted, j;
      out_beat_t           pick;
      nb = (bucket_count > MAX_BUCKETS_DEF) ? MAX_BUCKETS_DEF : bucket_count;
      total = (beat.replica_count < nb) ? beat.replica_count : nb;
      for (int i = 0; i < MAX_BUCKETS_DEF; i++) left_list[i] = BUCKET_W'(i);
      left    = nb;
      key     = beat.key_hash;
      emitted = 0;
      while (emitted < total && left > 0) begin
        j = jump_bucket(key, left);
        if (j >= left) j = left - 1;
        emitted++;
        pick.bucket = left_list[j];
        pick.last   = (emitted == total);
        picks_due.push_back(pick);
        if (pick.last) break;
        key ^= key >> XS_A;
        key ^= key << XS_B;
        key ^= key >> XS_C;
        key *= SCRAMBLE_MULT;
        left--;
        left_list[j] = left_list[left];
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      if (picks_due.size() == 0) begin
        report($sformatf("unexpected beat bucket=%0d last=%0b", got.bucket, got.last));
      end else begin
        want = picks_due.pop_front();
        if (got.bucket !== want.bucket)
          report($sformatf("bucket %0d, expected %0d", got.bucket, want.bucket));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid, in_stall;
  in_beat_t  in_data;
  logic      out_valid, out_stall;
  out_beat_t out_data;
  logic      cfg_valid, cfg_ready;
  logic [CFG_W-1:0] cfg_bucket_count;

  bucket_scoreboard sb = new();

  int  stall_mode;
  int  hold_cycles;
  int  idle_cycles;
  bit  timed_out;

  always #10 clk = ~clk;

  jump_hash_replica_select u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_bucket_count(cfg_bucket_count)
  );

  // Receiver stall pattern; a pending hold-off takes priority.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task send_key(logic [KEY_W-1:0] key, logic [CFG_W-1:0] replicas);
    @(negedge clk);
    in_valid              = 1'b1;
    in_data.key_hash      = key;
    in_data.replica_count = replicas;
    do @(posedge clk); while (in_stall);
    sb.note_input(in_data);
  endtask

  task pause_sender(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits until the block has drained, then writes the bucket count.
  task write_bucket_count(logic [CFG_W-1:0] value);
    pause_sender(0);
    wait (sb.picks_due.size() == 0);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_valid        = 1'b1;
    cfg_bucket_count = value;
    do @(posedge clk); while (!cfg_ready);
    sb.bucket_count = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task random_phase(int items, int max_replicas);
    int sent;
    int burst;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < items; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_key(rand_key(), CFG_W'($urandom_range(0, 63)));
        else
          send_key(rand_key(), CFG_W'($urandom_range(1, max_replicas)));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 40));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] counts [10] = '{6'd32, 6'd1, 6'd7, 6'd0, 6'd63, 6'd16, 6'd33,
                                      6'd3, 6'd24, 6'd32};
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_bucket_count = '0;
    stall_mode       = 0;
    hold_cycles      = 0;
    idle_cycles      = 0;
    timed_out        = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Reset count of one bucket, then the directed corners at full width.
    send_key(64'h0, 6'd5);
    write_bucket_count(6'd32);
    send_key(64'h0, 6'd1);
    send_key({KEY_W{1'b1}}, 6'd32);
    send_key(64'h0123_4567_89ab_cdef, 6'd0);
    send_key(64'h8000_0000_0000_0000, 6'd33);
    send_key(rand_key(), 6'd63);
    send_key(64'h1, 6'd31);
    write_bucket_count(6'd0);
    send_key(rand_key(), 6'd4);
    send_key(rand_key(), 6'd63);
    write_bucket_count(6'd63);
    send_key(rand_key(), 6'd63);
    send_key({KEY_W{1'b1}}, 6'd2);
    write_bucket_count(6'd1);
    send_key(rand_key(), 6'd1);
    send_key(rand_key(), 6'd40);

    for (int p = 0; p < 10; p++) begin
      write_bucket_count(counts[p]);
      stall_mode = p % 4;
      // In one phase the receiver holds off long enough for the input to back up.
      if (p == 2) begin
        @(negedge clk);
        hold_cycles = 600;
      end
      random_phase(42, (p % 3 == 0) ? 32 : 8);
    end

    pause_sender(0);
    wait (sb.picks_due.size() == 0);
    repeat (SETTLE_CYC) @(negedge clk);
    if (sb.mismatches == 0 && sb.picks_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
